@@ src/fbpa_pkg.sv @@
package fbpa_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS     = 1024;
  localparam int MIN_ELEM_BYTES = 8;

  // Field widths.
  localparam int ADDR_W   = 32;
  localparam int ELEM_W   = 16;
  localparam int ALIGN_W  = 13;
  localparam int MASK_W   = ALIGN_W - 1;
  localparam int STRIDE_W = ELEM_W + 1;
  localparam int CFG_W    = 32;

  // A block index, and a link that can also hold the end-of-list marker.
  localparam int QB    = $clog2(MAX_BLOCKS);
  localparam int IDX_W = $clog2(MAX_BLOCKS + 1);

  // The divider produces QB quotient bits; the dividend is below stride * MAX_BLOCKS.
  localparam int DIVW    = STRIDE_W + QB;
  localparam int DCNT_W  = $clog2(QB + 1);
  localparam int CMP_W   = ADDR_W + 2;

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration reset values.
  localparam logic [ELEM_W-1:0]  RESET_ELEM_BYTES = ELEM_W'(8);
  localparam logic [ALIGN_W-1:0] RESET_ELEM_ALIGN = ALIGN_W'(8);

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_FREE  = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_ALLOC,
    OP_FREE,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_POOL_BYTES = 2'd1,
    CFG_ELEM_BYTES = 2'd2,
    CFG_ELEM_ALIGN = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    action_t            action;
    logic [ADDR_W-1:0]  block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  result_address;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  address;
  } item_t;

  typedef struct packed {
    logic               valid;
    item_t              item;
  } q_head_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pool_base;
    logic [ADDR_W-1:0]  pool_bytes;
    logic [ELEM_W-1:0]  elem_bytes;
    logic [ALIGN_W-1:0] block_align;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [QB-1:0]      addr;
    logic [IDX_W-1:0]   data;
  } link_wr_t;

endpackage

@@ src/fbpa_ram.sv @@
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fbpa_front.sv @@
module fbpa_front
  import fbpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  req_t  request,
  input  logic  q_full,
  output logic  busy,
  output logic  push,
  output item_t push_item
);

  logic  stage_valid;
  item_t stage_item;
  logic  accept;
  op_t   op_class;

  // Holding a beat is only a problem when the queue cannot take it this cycle.
  assign busy      = stage_valid && q_full;
  assign accept    = start && !busy;
  assign push      = stage_valid && !q_full;
  assign push_item = stage_item;

  always_comb begin
    unique case (request.action)
      ACT_INIT:  op_class = OP_INIT;
      ACT_ALLOC: op_class = OP_ALLOC;
      ACT_FREE:  op_class = OP_FREE;
      default:   op_class = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
    if (accept) begin
      stage_item.op      <= op_class;
      stage_item.address <= request.block_address;
    end
  end

endmodule

@@ src/fbpa_queue.sv @@
module fbpa_queue
  import fbpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  item_t             push_item,
  input  logic              pop,
  output logic              full,
  output q_head_t           head,
  output logic [QCNT_W-1:0] count
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ src/fbpa_back.sv @@
module fbpa_back
  import fbpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  q_head_t          head,
  output logic             pop,
  output link_wr_t         link_wr,
  output logic [QB-1:0]    link_raddr,
  input  logic [IDX_W-1:0] link_rdata,
  output logic             done,
  output rsp_t             result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_INIT_CHK,
    S_RANGE,
    S_DIV,
    S_WALK
  } state_t;

  state_t              state;
  logic [IDX_W-1:0]    free_head;
  logic [IDX_W-1:0]    block_total;
  logic [ADDR_W-1:0]   aligned_base;
  logic [STRIDE_W-1:0] block_stride;
  logic [ADDR_W:0]     work_base;
  logic [ADDR_W:0]     limit;
  logic [CMP_W-1:0]    numer;
  logic                is_free;
  logic [DIVW-1:0]     prod;
  logic [DIVW-1:0]     rem;
  logic [DIVW-1:0]     dsr;
  logic [QB-1:0]       quo;
  logic [DCNT_W-1:0]   div_cnt;
  logic [IDX_W-1:0]    walk_idx;

  logic [ALIGN_W-1:0]  sm1, sm2, sm4, sm8;
  logic [MASK_W-1:0]   mask;
  logic [ELEM_W-1:0]   elem_eff;
  logic [ADDR_W:0]     base_up;
  logic [STRIDE_W-1:0] stride_up;
  logic [ADDR_W:0]     region_end;
  logic [ADDR_W:0]     limit_up;
  logic [CMP_W-1:0]    room;
  logic [CMP_W-1:0]    stride_max;
  logic [DIVW:0]       trial;
  logic                trial_ok;
  logic [DIVW-1:0]     rem_final;
  logic [QB-1:0]       quo_final;
  logic                free_ok;
  logic [IDX_W-1:0]    walk_succ;
  logic                walk_last;

  // Alignment mask: smear the alignment down and drop its top bit, so a value
  // that is not a power of two acts as its highest set bit and zero acts as one.
  always_comb begin
    sm1        = cfg.block_align | (cfg.block_align >> 1);
    sm2        = sm1 | (sm1 >> 2);
    sm4        = sm2 | (sm2 >> 4);
    sm8        = sm4 | (sm4 >> 8);
    mask       = MASK_W'(sm8 >> 1);
    elem_eff   = (cfg.elem_bytes < ELEM_W'(MIN_ELEM_BYTES)) ?
                 ELEM_W'(MIN_ELEM_BYTES) : cfg.elem_bytes;
    base_up    = ({1'b0, cfg.pool_base} + (ADDR_W+1)'(mask)) & ~(ADDR_W+1)'(mask);
    stride_up  = ({1'b0, elem_eff} + STRIDE_W'(mask)) & ~STRIDE_W'(mask);
    region_end = {1'b0, cfg.pool_base} + {1'b0, cfg.pool_bytes};
    limit_up   = region_end[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : region_end;
    room       = CMP_W'(limit) - CMP_W'(work_base) - CMP_W'(elem_eff);
    stride_max = CMP_W'(block_stride) * CMP_W'(MAX_BLOCKS);
    trial      = {1'b0, rem} - {1'b0, dsr};
    trial_ok   = !trial[DIVW];
    rem_final  = trial_ok ? trial[DIVW-1:0] : rem;
    quo_final  = QB'({quo, trial_ok});
    free_ok    = (rem_final == '0) && (IDX_W'(quo_final) < block_total);
    walk_succ  = walk_idx + IDX_W'(1);
    walk_last  = (walk_succ == block_total);
  end

  assign pop        = (state == S_IDLE) && head.valid;
  assign link_raddr = free_head[QB-1:0];

  always_comb begin
    link_wr.we   = 1'b0;
    link_wr.addr = walk_idx[QB-1:0];
    link_wr.data = walk_last ? IDX_W'(MAX_BLOCKS) : walk_succ;
    if (state == S_WALK) begin
      link_wr.we = 1'b1;
    end else if (state == S_DIV && div_cnt == '0 && is_free && free_ok) begin
      link_wr.we   = 1'b1;
      link_wr.addr = quo_final;
      link_wr.data = free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_head    <= IDX_W'(MAX_BLOCKS);
      block_total  <= '0;
      aligned_base <= '0;
      block_stride <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            unique case (head.item.op)
              OP_INIT: begin
                work_base    <= base_up;
                aligned_base <= base_up[ADDR_W-1:0];
                block_stride <= stride_up;
                limit        <= limit_up;
                free_head    <= IDX_W'(MAX_BLOCKS);
                block_total  <= '0;
                is_free      <= 1'b0;
                state        <= S_INIT_CHK;
              end
              OP_ALLOC: begin
                if (free_head == IDX_W'(MAX_BLOCKS)) begin
                  done   <= 1'b1;
                  result <= '{result_address: '0, status: ST_EMPTY};
                end else begin
                  prod  <= DIVW'(free_head[QB-1:0]) * DIVW'(block_stride);
                  state <= S_ALLOC;
                end
              end
              OP_FREE: begin
                if (block_total == '0 || head.item.address < aligned_base) begin
                  done   <= 1'b1;
                  result <= '{result_address: '0, status: ST_BAD_FREE};
                end else begin
                  numer   <= CMP_W'(head.item.address - aligned_base);
                  is_free <= 1'b1;
                  state   <= S_RANGE;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '{result_address: '0, status: ST_OK};
              end
            endcase
          end
        end
        S_ALLOC: begin
          free_head <= link_rdata;
          done      <= 1'b1;
          result    <= '{result_address: aligned_base + ADDR_W'(prod), status: ST_OK};
          state     <= S_IDLE;
        end
        S_INIT_CHK: begin
          if (room[CMP_W-1]) begin
            done   <= 1'b1;
            result <= '{result_address: '0, status: ST_TOO_SMALL};
            state  <= S_IDLE;
          end else begin
            numer <= room;
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (numer >= stride_max) begin
            if (is_free) begin
              done   <= 1'b1;
              result <= '{result_address: '0, status: ST_BAD_FREE};
              state  <= S_IDLE;
            end else begin
              block_total <= IDX_W'(MAX_BLOCKS);
              walk_idx    <= '0;
              state       <= S_WALK;
            end
          end else begin
            rem     <= numer[DIVW-1:0];
            dsr     <= DIVW'(block_stride) << (QB - 1);
            quo     <= '0;
            div_cnt <= DCNT_W'(QB - 1);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_final;
          quo <= quo_final;
          dsr <= dsr >> 1;
          if (div_cnt == '0) begin
            if (is_free) begin
              done  <= 1'b1;
              state <= S_IDLE;
              if (free_ok) begin
                free_head <= IDX_W'(quo_final);
                result    <= '{result_address: '0, status: ST_OK};
              end else begin
                result    <= '{result_address: '0, status: ST_BAD_FREE};
              end
            end else begin
              block_total <= IDX_W'(quo_final) + IDX_W'(1);
              walk_idx    <= '0;
              state       <= S_WALK;
            end
          end else begin
            div_cnt <= div_cnt - DCNT_W'(1);
          end
        end
        S_WALK: begin
          walk_idx <= walk_succ;
          if (walk_last) begin
            free_head <= '0;
            done      <= 1'b1;
            result    <= '{result_address: '0, status: ST_OK};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator. An init beat carves the configured region
// into equal blocks (stride = element size, at least the minimum, rounded up to
// the alignment; base rounded up to the alignment; at most MAX_BLOCKS blocks)
// and chains them into a LIFO free list; an alloc beat pops the head block and
// returns its address; a free beat turns an address back into a block index and
// pushes it. Every accepted beat yields exactly one result beat, in order, shown
// for one cycle with done high; the receiver cannot stall, so it must take every
// result as it appears. A beat is accepted when start is high and busy is low.
// Behind the input register a two-entry queue lets new beats be taken while the
// execution engine works, so busy only rises when both are full. An undefined
// action, an alloc on an empty pool or an obviously bad free is answered from
// idle; an alloc does one link-memory read; a free runs the one-bit-per-cycle
// divider that maps the address offset to a block index, unless the offset
// lies beyond the largest possible pool; an init checks the region size, runs
// the divider to count the blocks and then writes the link memory one entry
// per cycle. An init whose region is too small stops after the size check,
// and one whose count saturates skips the divider.
// Double frees are not detected. Configuration registers may be written only
// while no beat is outstanding.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             request,
  output logic             busy,
  output logic             done,
  output rsp_t             result,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              q_push;
  item_t             q_push_item;
  logic              q_pop;
  logic              q_full;
  q_head_t           q_head;
  logic [QCNT_W-1:0] q_count;
  link_wr_t          link_wr;
  logic [QB-1:0]     link_raddr;
  logic [IDX_W-1:0]  link_rdata;

  // Configuration registers. Each write keeps the low bits the register holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_base   <= '0;
      cfg.pool_bytes  <= '0;
      cfg.elem_bytes  <= RESET_ELEM_BYTES;
      cfg.block_align <= RESET_ELEM_ALIGN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE:  cfg.pool_base   <= cfg_data[ADDR_W-1:0];
        CFG_POOL_BYTES: cfg.pool_bytes  <= cfg_data[ADDR_W-1:0];
        CFG_ELEM_BYTES: cfg.elem_bytes  <= cfg_data[ELEM_W-1:0];
        CFG_ELEM_ALIGN: cfg.block_align <= cfg_data[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // The front registers each accepted beat and decodes its action.
  fbpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .q_full    (q_full),
    .busy      (busy),
    .push      (q_push),
    .push_item (q_push_item)
  );

  fbpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .full      (q_full),
    .head      (q_head),
    .count     (q_count)
  );

  // The back owns the pool state and runs init, alloc and free one at a time.
  fbpa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (q_head),
    .pop        (q_pop),
    .link_wr    (link_wr),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .done       (done),
    .result     (result)
  );

  // Per-block next links of the free list.
  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_links (
    .clk   (clk),
    .we    (link_wr.we),
    .waddr (link_wr.addr),
    .wdata (link_wr.data),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // The back never takes an entry the queue does not hold.
  a_pop_has_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("queue popped while empty");

  // The queue count never passes its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("queue count past depth");

  // Only a successful allocation carries an address.
  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.result_address == '0)
    else $error("address on a failed result");

  // Nothing can be outstanding right after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done && q_count == '0)
    else $error("result or queued beat right after reset");

endmodule
